// ===== design/byte_ring_fifo_overwrite_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Byte ring FIFO assertion macros
// Shorthand for the concurrent checks used inside the RTL modules. The checks
// compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef BYTE_RING_FIFO_OVERWRITE_UNIT_MACROS_SVH
`define BYTE_RING_FIFO_OVERWRITE_UNIT_MACROS_SVH
`ifndef SYNTH
// A property that must hold at every clock edge outside reset.
`define BRFO_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);
// When the first expression holds, the second must hold in the next cycle.
`define BRFO_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define BRFO_ASSERT(lbl, prop, msg)
`define BRFO_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== design/brfo_pkg.sv =====
// ----------------------------------------------------------------------------
// Byte ring FIFO package
// Command and status codes, transaction payload types and the control and
// status structs shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package brfo_pkg;

	localparam int LEVEL_W    = 9;
	localparam int COUNT_W    = 7;
	localparam int BYTE_W     = 8;
	localparam int CMD_W      = 3;
	localparam int STATUS_W   = 2;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;

	// Register indexes, taken from paddr[2].
	localparam logic REG_OVERWRITE = 1'b0;
	localparam logic REG_CAPACITY  = 1'b1;

	localparam logic [LEVEL_W-1:0] CAPACITY_RESET = 9'd256;

	typedef enum logic [CMD_W-1:0] {
		CMD_WRITE = 3'd0,
		CMD_READ  = 3'd1,
		CMD_PEEK  = 3'd2,
		CMD_SKIP  = 3'd3,
		CMD_CLEAR = 3'd4
	} cmd_e_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK          = 2'd0,
		ST_NONE        = 2'd1,
		ST_DROPPED     = 2'd2,
		ST_OVERWRITTEN = 2'd3
	} status_e_t;

	typedef enum logic {
		S_IDLE  = 1'b0,
		S_BURST = 1'b1
	} ctrl_state_t;

	typedef struct packed {
		logic [CMD_W-1:0]   command;
		logic [BYTE_W-1:0]  data_byte;
		logic [COUNT_W-1:0] request_count;
	} in_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0]   out_byte;
		logic                has_byte;
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0]  moved_count;
		logic [LEVEL_W-1:0]  fill_level;
		logic [LEVEL_W-1:0]  free_space;
		logic                is_last;
	} out_item_t;

	// Controller to datapath.
	typedef struct packed {
		logic accept;  // execute the command on the input port
		logic step;    // fetch the next byte of a read or peek burst
		logic last;    // the result loaded now closes the command
	} ctrl_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic               is_burst;  // read or peek that delivers bytes
		logic [COUNT_W-1:0] burst_n;   // bytes the command will deliver
	} dp_status_t;

endpackage

// ===== design/brfo_regs.sv =====
// ----------------------------------------------------------------------------
// Byte ring FIFO configuration registers
// APB-style register file holding the overwrite mode and the capacity.
// ----------------------------------------------------------------------------
module brfo_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [brfo_pkg::CFG_ADDR_W-1:0]     paddr,
	input  logic [brfo_pkg::CFG_DATA_W-1:0]     pwdata,
	output logic [brfo_pkg::CFG_DATA_W-1:0]     prdata,
	output logic                                pready,
	output logic                                overwrite_mode,
	output logic [brfo_pkg::LEVEL_W-1:0]        capacity
);

	logic                         overwrite_q;
	logic [brfo_pkg::LEVEL_W-1:0] capacity_q;
	logic                         wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			overwrite_q <= 1'b0;
			capacity_q  <= brfo_pkg::CAPACITY_RESET;
		end else if (wr_en) begin
			if (paddr[2] == brfo_pkg::REG_CAPACITY) begin
				capacity_q <= pwdata[brfo_pkg::LEVEL_W-1:0];
			end else begin
				overwrite_q <= pwdata[0];
			end
		end
	end

	always_comb begin
		if (paddr[2] == brfo_pkg::REG_CAPACITY) begin
			prdata = {{(brfo_pkg::CFG_DATA_W-brfo_pkg::LEVEL_W){1'b0}}, capacity_q};
		end else begin
			prdata = {{(brfo_pkg::CFG_DATA_W-1){1'b0}}, overwrite_q};
		end
	end

	assign overwrite_mode = overwrite_q;
	assign capacity       = capacity_q;

endmodule

// ===== design/brfo_ctrl.sv =====
// ----------------------------------------------------------------------------
// Byte ring FIFO controller
// Sequences commands and read bursts and owns the result valid flag.
// ----------------------------------------------------------------------------
`include "byte_ring_fifo_overwrite_unit_macros.svh"

module brfo_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   item_ready,
	output logic                   result_valid,
	input  logic                   result_ready,
	input  brfo_pkg::dp_status_t   st,
	output brfo_pkg::ctrl_cmd_t    cmd
);

	brfo_pkg::ctrl_state_t          state_q, state_d;
	logic [brfo_pkg::COUNT_W-1:0]   remain_q, remain_d;
	logic                           valid_q;
	logic                           slot_free;

	// The result register can take a new result when empty or being drained.
	assign slot_free = !valid_q || result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= brfo_pkg::S_IDLE;
			remain_q <= '0;
			valid_q  <= 1'b0;
		end else begin
			state_q  <= state_d;
			remain_q <= remain_d;
			if (cmd.accept || cmd.step) begin
				valid_q <= 1'b1;
			end else if (result_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d    = state_q;
		remain_d   = remain_q;
		cmd        = '0;
		item_ready = 1'b0;
		case (state_q)
			brfo_pkg::S_IDLE: begin
				item_ready = slot_free;
				cmd.accept = item_valid && slot_free;
				cmd.last   = !(st.is_burst && (st.burst_n > 7'd1));
				if (cmd.accept && !cmd.last) begin
					state_d  = brfo_pkg::S_BURST;
					remain_d = st.burst_n - 7'd1;
				end
			end
			brfo_pkg::S_BURST: begin
				cmd.step = slot_free;
				cmd.last = (remain_q == 7'd1);
				if (cmd.step) begin
					remain_d = remain_q - 7'd1;
					if (cmd.last) begin
						state_d = brfo_pkg::S_IDLE;
					end
				end
			end
			default: begin
				state_d = brfo_pkg::S_IDLE;
			end
		endcase
	end

	assign result_valid = valid_q;

	`BRFO_ASSERT_NEXT(a_burst_entry, cmd.accept && !cmd.last, state_q == brfo_pkg::S_BURST, "multi-byte burst did not start")
	`BRFO_ASSERT(a_burst_count, (state_q == brfo_pkg::S_BURST) |-> (remain_q != '0), "burst running with no bytes left")
	`BRFO_ASSERT_NEXT(a_burst_exit, cmd.step && cmd.last, state_q == brfo_pkg::S_IDLE, "burst did not end after its last byte")

endmodule

// ===== design/brfo_dp.sv =====
// ----------------------------------------------------------------------------
// Byte ring FIFO datapath
// Pointers, fill level, byte memory and the result register.
// ----------------------------------------------------------------------------
`include "byte_ring_fifo_overwrite_unit_macros.svh"

module brfo_dp #(
	parameter int STORE_DEPTH = 256,
	parameter int MAX_BURST   = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  brfo_pkg::in_item_t   item,
	input  brfo_pkg::ctrl_cmd_t  cmd,
	input  logic                 overwrite_mode,
	input  logic [brfo_pkg::LEVEL_W-1:0] capacity,
	output brfo_pkg::dp_status_t st,
	output brfo_pkg::out_item_t  result
);

	localparam int PW = $clog2(STORE_DEPTH);
	localparam int CW = ((PW > brfo_pkg::LEVEL_W) ? PW : brfo_pkg::LEVEL_W) + 1;
	localparam logic [brfo_pkg::LEVEL_W-1:0] RESET_CAP =
		(STORE_DEPTH < 256) ? brfo_pkg::LEVEL_W'(STORE_DEPTH) : brfo_pkg::CAPACITY_RESET;

	logic [PW-1:0]                 wr_ptr_q, wr_ptr_d;
	logic [PW-1:0]                 rd_ptr_q, rd_ptr_d;
	logic [PW-1:0]                 burst_ptr_q;
	logic [brfo_pkg::LEVEL_W-1:0]  held_q, held_d;
	logic [brfo_pkg::LEVEL_W-1:0]  cap_q, cap_d;
	logic [brfo_pkg::LEVEL_W-1:0]  lim_cap;
	logic [brfo_pkg::LEVEL_W-1:0]  req_lvl, lim;
	logic [brfo_pkg::COUNT_W-1:0]  n;
	logic [PW-1:0]                 rd_wrap;
	logic                          full;
	logic                          mem_we;
	logic                          is_burst;
	logic                          rd_en;
	logic [PW-1:0]                 raddr;

	logic [brfo_pkg::BYTE_W-1:0]   mem [STORE_DEPTH];
	logic [brfo_pkg::BYTE_W-1:0]   rdata_q;

	logic                          has_q, has_d;
	logic [brfo_pkg::STATUS_W-1:0] status_q;
	brfo_pkg::status_e_t           status_d;
	logic [brfo_pkg::COUNT_W-1:0]  moved_q, moved_d;
	logic [brfo_pkg::LEVEL_W-1:0]  fill_q, free_q, free_d;
	logic                          last_q;

	function automatic logic [PW-1:0] adv(input logic [PW-1:0] p,
		input logic [brfo_pkg::LEVEL_W-1:0] c);
		logic [CW-1:0] s;
		s = CW'(p) + CW'(1);
		return (s >= CW'(c)) ? '0 : s[PW-1:0];
	endfunction

	// p + k stays below twice the capacity, so one subtract wraps it.
	function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] p,
		input logic [brfo_pkg::COUNT_W-1:0] k, input logic [brfo_pkg::LEVEL_W-1:0] c);
		logic [CW-1:0] s;
		s = CW'(p) + CW'(k);
		if (s >= CW'(c)) begin
			s = s - CW'(c);
		end
		return s[PW-1:0];
	endfunction

	always_comb begin
		if (capacity == '0) begin
			lim_cap = brfo_pkg::LEVEL_W'(1);
		end else if (CW'(capacity) > CW'(STORE_DEPTH)) begin
			lim_cap = brfo_pkg::LEVEL_W'(STORE_DEPTH);
		end else begin
			lim_cap = capacity;
		end
	end

	assign full    = (held_q >= cap_q);
	assign req_lvl = brfo_pkg::LEVEL_W'(item.request_count);

	always_comb begin
		lim = (held_q < req_lvl) ? held_q : req_lvl;
		if (lim > brfo_pkg::LEVEL_W'(MAX_BURST)) begin
			lim = brfo_pkg::LEVEL_W'(MAX_BURST);
		end
		n = lim[brfo_pkg::COUNT_W-1:0];
	end

	assign rd_wrap = wrap_add(rd_ptr_q, n, cap_q);

	always_comb begin
		wr_ptr_d = wr_ptr_q;
		rd_ptr_d = rd_ptr_q;
		held_d   = held_q;
		cap_d    = cap_q;
		status_d = brfo_pkg::ST_NONE;
		moved_d  = '0;
		has_d    = 1'b0;
		mem_we   = 1'b0;
		is_burst = 1'b0;
		case (brfo_pkg::cmd_e_t'(item.command))
			brfo_pkg::CMD_WRITE: begin
				if (full && !overwrite_mode) begin
					status_d = brfo_pkg::ST_DROPPED;
				end else begin
					mem_we   = 1'b1;
					wr_ptr_d = adv(wr_ptr_q, cap_q);
					moved_d  = brfo_pkg::COUNT_W'(1);
					if (full) begin
						// The oldest byte makes room; the level stays at capacity.
						rd_ptr_d = adv(rd_ptr_q, cap_q);
						status_d = brfo_pkg::ST_OVERWRITTEN;
					end else begin
						held_d   = held_q + brfo_pkg::LEVEL_W'(1);
						status_d = brfo_pkg::ST_OK;
					end
				end
			end
			brfo_pkg::CMD_READ, brfo_pkg::CMD_PEEK: begin
				if (n != '0) begin
					is_burst = 1'b1;
					has_d    = 1'b1;
					status_d = brfo_pkg::ST_OK;
					moved_d  = n;
					if (brfo_pkg::cmd_e_t'(item.command) == brfo_pkg::CMD_READ) begin
						rd_ptr_d = rd_wrap;
						held_d   = held_q - brfo_pkg::LEVEL_W'(n);
					end
				end
			end
			brfo_pkg::CMD_SKIP: begin
				if (n != '0) begin
					rd_ptr_d = rd_wrap;
					held_d   = held_q - brfo_pkg::LEVEL_W'(n);
					status_d = brfo_pkg::ST_OK;
					moved_d  = n;
				end
			end
			brfo_pkg::CMD_CLEAR: begin
				wr_ptr_d = '0;
				rd_ptr_d = '0;
				held_d   = '0;
				cap_d    = lim_cap;
				status_d = brfo_pkg::ST_OK;
			end
			default: begin
				status_d = brfo_pkg::ST_NONE;
			end
		endcase
		free_d = cap_d - held_d;
	end

	assign st.is_burst = is_burst;
	assign st.burst_n  = n;

	// The first byte is fetched with the command, later ones one per step.
	assign rd_en = (cmd.accept && is_burst) || cmd.step;
	assign raddr = cmd.accept ? rd_ptr_q : burst_ptr_q;

	always_ff @(posedge clk) begin
		if (cmd.accept && mem_we) begin
			mem[wr_ptr_q] <= item.data_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			held_q   <= '0;
			cap_q    <= RESET_CAP;
		end else if (cmd.accept) begin
			wr_ptr_q <= wr_ptr_d;
			rd_ptr_q <= rd_ptr_d;
			held_q   <= held_d;
			cap_q    <= cap_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			burst_ptr_q <= adv(rd_ptr_q, cap_q);
			has_q       <= has_d;
			status_q    <= status_d;
			moved_q     <= moved_d;
			fill_q      <= held_d;
			free_q      <= free_d;
			last_q      <= cmd.last;
		end else if (cmd.step) begin
			burst_ptr_q <= adv(burst_ptr_q, cap_q);
			last_q      <= cmd.last;
		end
	end

	assign result.out_byte    = has_q ? rdata_q : '0;
	assign result.has_byte    = has_q;
	assign result.status      = status_q;
	assign result.moved_count = moved_q;
	assign result.fill_level  = fill_q;
	assign result.free_space  = free_q;
	assign result.is_last     = last_q;

	`BRFO_ASSERT(a_level_bound, held_q <= cap_q, "fill level above active capacity")
	`BRFO_ASSERT(a_ptr_bound, (CW'(rd_ptr_q) < CW'(cap_q)) && (CW'(wr_ptr_q) < CW'(cap_q)), "pointer beyond wrap point")

endmodule

// ===== design/byte_ring_fifo_overwrite_unit.sv =====
// ----------------------------------------------------------------------------
// Byte ring FIFO with overwrite
// Circular byte buffer driven by write, read, peek, skip and clear commands.
// ----------------------------------------------------------------------------
// Write, skip, clear and commands that move nothing finish on acceptance, so a
// stream of them is accepted back to back while results are drained. A read or
// peek that delivers n bytes (n limited to the fill level and to MAX_BURST)
// holds the block while the single read port of the byte memory fetches one
// byte per cycle while the result register is free, and then takes new commands.
// Every result of a read or peek already reports the fill level and free
// space after the command. A new capacity written over the register port
// takes effect only at the next clear command; the memory needs no clearing
// pass after reset, and bytes are read back only after they were written.
module byte_ring_fifo_overwrite_unit #(
	parameter int STORE_DEPTH = 256,
	parameter int MAX_BURST   = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_valid,
	output logic                             item_ready,
	input  brfo_pkg::in_item_t               item,
	output logic                             result_valid,
	input  logic                             result_ready,
	output brfo_pkg::out_item_t              result,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [brfo_pkg::CFG_ADDR_W-1:0]  paddr,
	input  logic [brfo_pkg::CFG_DATA_W-1:0]  pwdata,
	output logic [brfo_pkg::CFG_DATA_W-1:0]  prdata,
	output logic                             pready
);

	logic                         overwrite_mode;
	logic [brfo_pkg::LEVEL_W-1:0] capacity;
	brfo_pkg::ctrl_cmd_t          cmd;
	brfo_pkg::dp_status_t         st;

	brfo_regs u_regs (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.overwrite_mode (overwrite_mode),
		.capacity       (capacity)
	);

	brfo_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.st           (st),
		.cmd          (cmd)
	);

	brfo_dp #(
		.STORE_DEPTH (STORE_DEPTH),
		.MAX_BURST   (MAX_BURST)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.item           (item),
		.cmd            (cmd),
		.overwrite_mode (overwrite_mode),
		.capacity       (capacity),
		.st             (st),
		.result         (result)
	);

endmodule
